FILE: hdl/gapa_pkg.sv
// Shared types and constants for the global average pooling / argmax block.
`timescale 1ns / 1ps
`default_nettype none

package gapa_pkg;

  localparam int ACT_W       = 8;
  localparam int ZP_W        = 8;
  localparam int SIDE_W      = 5;
  localparam int CNT_W       = 5;
  localparam int IDX_W       = 4;
  localparam int LOGIT_W     = 9;
  localparam int QUOT_W      = 8;
  localparam int STEP_W      = 3;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 8;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 24;
  localparam int OUT_PAD_W   = OUT_TDATA_W - (2 * IDX_W + LOGIT_W);

  // Register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_POINT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIDE_LENGTH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd2;

  localparam int SIDE_RESET_VAL = 10;
  localparam int CNT_RESET_VAL  = 3;

  localparam logic [ZP_W-1:0]   ZP_RESET   = 8'h80;
  localparam logic [SIDE_W-1:0] SIDE_RESET = 5'd10;
  localparam logic [CNT_W-1:0]  CNT_RESET  = 5'd3;
  localparam logic [STEP_W-1:0] STEP_FIRST = 3'd7;

  typedef enum logic [1:0] {
    ST_ACCUM,
    ST_DIVIDE,
    ST_EMIT
  } gapa_state_t;

  typedef struct packed {
    logic accum;
    logic cfg_wr;
    logic div_step;
    logic emit;
  } gapa_cmd_t;

  typedef struct packed {
    logic last_pixel;
    logic div_last;
    logic out_free;
  } gapa_sts_t;

endpackage

`default_nettype wire

FILE: hdl/gapa_ctrl.sv
// Controller state machine: accumulate, divide, emit.
`timescale 1ns / 1ps
`default_nettype none

module gapa_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire gapa_pkg::gapa_sts_t  sts,
  output gapa_pkg::gapa_cmd_t       cmd
);
  import gapa_pkg::*;

  gapa_state_t state_r;
  gapa_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_ACCUM;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_ACCUM: begin
        if (in_tvalid && !cfg_valid && sts.last_pixel) begin
          state_nxt = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (sts.div_last) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          state_nxt = ST_ACCUM;
        end
      end
      default: state_nxt = ST_ACCUM;
    endcase
  end

  always_comb begin
    cfg_ready    = 1'b0;
    in_tready    = 1'b0;
    cmd.div_step = 1'b0;
    cmd.emit     = 1'b0;
    case (state_r)
      ST_ACCUM: begin
        cfg_ready = 1'b1;
        // a configuration transaction wins over an activation
        in_tready = !cfg_valid;
      end
      ST_DIVIDE: cmd.div_step = 1'b1;
      ST_EMIT:   cmd.emit     = sts.out_free;
      default: begin
        cfg_ready = 1'b0;
        in_tready = 1'b0;
      end
    endcase
    cmd.accum  = in_tvalid && in_tready;
    cmd.cfg_wr = cfg_valid && cfg_ready;
  end

  a_last_pixel_divides: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.accum && sts.last_pixel) |=> (state_r == ST_DIVIDE))
    else $error("last pixel did not start the division");

  a_divide_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIVIDE && !sts.div_last) |=> (state_r == ST_DIVIDE))
    else $error("division left before its last step");

  a_no_input_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_ACCUM) |-> (!cmd.accum && !cmd.cfg_wr))
    else $error("transaction accepted while a channel is being finished");

endmodule

`default_nettype wire

FILE: hdl/gapa_dp.sv
// Datapath: configuration registers, accumulator, serial divider, argmax, output register.
`timescale 1ns / 1ps
`default_nettype none

module gapa_dp #(
  parameter int MAX_SIDE     = 16,
  parameter int MAX_CHANNELS = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire gapa_pkg::gapa_cmd_t                  cmd,
  output gapa_pkg::gapa_sts_t                       sts,
  input  wire logic [gapa_pkg::IN_TDATA_W-1:0]      in_tdata,
  input  wire logic [gapa_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [gapa_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  output logic [gapa_pkg::OUT_TDATA_W-1:0]          out_tdata,
  output logic                                      out_tlast
);
  import gapa_pkg::*;

  // The side register is 5 bits, so writes never exceed 31.
  localparam int SIDE_TOP  = (MAX_SIDE < 31) ? MAX_SIDE : 31;
  localparam int CH_TOP    = (MAX_CHANNELS < 31) ? MAX_CHANNELS : 31;
  localparam int SIDE_MAXV = (SIDE_TOP > SIDE_RESET_VAL) ? SIDE_TOP : SIDE_RESET_VAL;
  localparam int AREA_MAX  = SIDE_MAXV * SIDE_MAXV;
  localparam int AREA_W    = $clog2(AREA_MAX + 1);
  localparam int MAG_W     = $clog2(AREA_MAX * 255 + 1);
  localparam int SUM_W     = MAG_W + 1;
  localparam int TRIAL_W   = AREA_W + QUOT_W;
  localparam logic [SIDE_W-1:0] SIDE_LIMIT = SIDE_W'(SIDE_TOP);
  localparam logic [CNT_W-1:0]  CH_LIMIT   = CNT_W'(CH_TOP);
  localparam logic [AREA_W-1:0] AREA_RESET = AREA_W'(SIDE_RESET_VAL * SIDE_RESET_VAL);

  // configuration
  logic [ZP_W-1:0]   zero_point_r;
  logic [CNT_W-1:0]  channel_count_r;
  logic [AREA_W-1:0] area_r;

  // stream state
  logic [SUM_W-1:0]  sum_r;
  logic [AREA_W-1:0] pixel_cnt_r;
  logic [CNT_W-1:0]  ch_cnt_r;
  logic [LOGIT_W-1:0] best_val_r;
  logic [CNT_W-1:0]  best_ch_r;

  // divider
  logic [MAG_W-1:0]  rem_r;
  logic [QUOT_W-1:0] quot_r;
  logic [STEP_W-1:0] step_r;
  logic              neg_r;

  // output register
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;
  logic                   out_tlast_r;

  logic [SIDE_W-1:0]     cfg_val5;
  logic [2*SIDE_W-1:0]   area_prod;
  logic                  wr_zp, wr_side, wr_count, restart;
  logic [LOGIT_W-1:0]    diff;
  logic [SUM_W-1:0]      sum_nxt;
  logic [SUM_W-1:0]      sum_neg;
  logic [MAG_W-1:0]      mag;
  logic [AREA_W:0]       pixel_inc;
  logic [TRIAL_W-1:0]    area_shift;
  logic [TRIAL_W:0]      trial;
  logic [LOGIT_W-1:0]    logit;
  logic                  better;
  logic                  is_final;
  logic [CNT_W:0]        ch_inc;
  logic [CNT_W-1:0]      best_ch_nxt;

  assign cfg_val5  = cfg_data[SIDE_W-1:0];
  assign area_prod = {{SIDE_W{1'b0}}, cfg_val5} * {{SIDE_W{1'b0}}, cfg_val5};
  assign wr_zp     = cmd.cfg_wr && (cfg_index == REG_ZERO_POINT);
  assign wr_side   = cmd.cfg_wr && (cfg_index == REG_SIDE_LENGTH)
                     && (cfg_val5 != '0) && (cfg_val5 <= SIDE_LIMIT);
  assign wr_count  = cmd.cfg_wr && (cfg_index == REG_CHANNEL_COUNT)
                     && (cfg_val5 != '0) && (cfg_val5 <= CH_LIMIT);
  assign restart   = wr_zp || wr_side || wr_count;

  assign diff    = {in_tdata[ACT_W-1], in_tdata[ACT_W-1:0]}
                   - {zero_point_r[ZP_W-1], zero_point_r};
  assign sum_nxt = sum_r + {{(SUM_W-LOGIT_W){diff[LOGIT_W-1]}}, diff};
  assign sum_neg = '0 - sum_nxt;
  assign mag     = sum_nxt[SUM_W-1] ? sum_neg[MAG_W-1:0] : sum_nxt[MAG_W-1:0];

  assign pixel_inc = {1'b0, pixel_cnt_r} + (AREA_W+1)'(1);

  // one quotient bit per cycle, most significant first
  assign area_shift = TRIAL_W'(area_r) << step_r;
  assign trial      = {1'b0, TRIAL_W'(rem_r)} - {1'b0, area_shift};

  assign logit       = neg_r ? ('0 - {1'b0, quot_r}) : {1'b0, quot_r};
  assign better      = (ch_cnt_r == '0) || ($signed(logit) > $signed(best_val_r));
  assign ch_inc      = {1'b0, ch_cnt_r} + (CNT_W+1)'(1);
  assign is_final    = ch_inc >= {1'b0, channel_count_r};
  assign best_ch_nxt = better ? ch_cnt_r : best_ch_r;

  always_comb begin
    sts.last_pixel = (pixel_inc == {1'b0, area_r});
    sts.div_last   = (step_r == '0);
    sts.out_free   = !out_valid_r || out_tready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_point_r    <= ZP_RESET;
      channel_count_r <= CNT_RESET;
      area_r          <= AREA_RESET;
    end else begin
      if (wr_zp) begin
        zero_point_r <= cfg_data[ZP_W-1:0];
      end
      if (wr_side) begin
        area_r <= AREA_W'(area_prod);
      end
      if (wr_count) begin
        channel_count_r <= cfg_val5;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      pixel_cnt_r <= '0;
      ch_cnt_r    <= '0;
      best_val_r  <= '0;
      best_ch_r   <= '0;
    end else if (restart) begin
      sum_r       <= '0;
      pixel_cnt_r <= '0;
      ch_cnt_r    <= '0;
      best_val_r  <= '0;
      best_ch_r   <= '0;
    end else begin
      if (cmd.accum) begin
        if (sts.last_pixel) begin
          sum_r       <= '0;
          pixel_cnt_r <= '0;
        end else begin
          sum_r       <= sum_nxt;
          pixel_cnt_r <= pixel_inc[AREA_W-1:0];
        end
      end
      if (cmd.emit) begin
        if (is_final) begin
          ch_cnt_r   <= '0;
          best_val_r <= '0;
          best_ch_r  <= '0;
        end else begin
          ch_cnt_r  <= ch_inc[CNT_W-1:0];
          best_ch_r <= best_ch_nxt;
          if (better) begin
            best_val_r <= logit;
          end
        end
      end
    end
  end

  // divider registers carry payload only
  always_ff @(posedge clk) begin
    if (cmd.accum && sts.last_pixel) begin
      rem_r  <= mag;
      neg_r  <= sum_nxt[SUM_W-1];
      quot_r <= '0;
      step_r <= STEP_FIRST;
    end else if (cmd.div_step) begin
      quot_r <= {quot_r[QUOT_W-2:0], ~trial[TRIAL_W]};
      if (!trial[TRIAL_W]) begin
        rem_r <= trial[MAG_W-1:0];
      end
      step_r <= step_r - STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_tdata_r <= {{OUT_PAD_W{1'b0}}, best_ch_nxt[IDX_W-1:0], logit,
                      ch_cnt_r[IDX_W-1:0]};
      out_tlast_r <= is_final;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

  a_pixel_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    pixel_cnt_r < area_r)
    else $error("pixel counter ran past the channel area");

  a_channel_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ch_cnt_r < channel_count_r)
    else $error("channel counter ran past the channel count");

  a_remainder_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (TRIAL_W'(rem_r) < TRIAL_W'(area_r)))
    else $error("division remainder not below the divisor");

endmodule

`default_nettype wire

FILE: hdl/global_avg_pool_argmax_top.sv
// Top level: global average pooling per channel with running argmax.
//
//   channel | direction | tdata / data                               | extra
//   in_     | slave     | [7:0] activation                           | -
//   out_    | master    | [3:0] channel_index, [12:4] logit,         | tlast = is_final
//           |           | [16:13] best_class, [23:17] zero           |
//   cfg_    | slave     | cfg_index: register, cfg_data: value       | -
//
// An activation is taken every cycle while a channel accumulates and no
// configuration write is pending. On the last pixel of a channel the input
// stalls while the bit-serial divider runs and the result register is loaded;
// a result still unread when the next one is due holds the block.
// Reset (synchronous, rst_n low) sets zero_point -128, side 10, 3 channels.
`timescale 1ns / 1ps
`default_nettype none

module global_avg_pool_argmax_top #(
  parameter int MAX_SIDE     = 16,
  parameter int MAX_CHANNELS = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [gapa_pkg::IN_TDATA_W-1:0]  in_tdata,   // [7:0] activation
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // [3:0] channel_index, [12:4] logit, [16:13] best_class, [23:17] zero
  output logic [gapa_pkg::OUT_TDATA_W-1:0]      out_tdata,
  output logic                                  out_tlast,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [gapa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [gapa_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import gapa_pkg::*;

  gapa_cmd_t cmd;
  gapa_sts_t sts;

  gapa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  gapa_dp #(
    .MAX_SIDE     (MAX_SIDE),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire
